FILE: design/sdmf_pkg.sv
`timescale 1ns / 1ps
package sdmf_pkg;

   localparam int unsigned BEFORE1 = 2;
   localparam int unsigned AFTER1  = 2;
   localparam int unsigned BEFORE2 = 2;
   localparam int unsigned AFTER2  = 2;

   localparam int unsigned MAXB     = (BEFORE1 > BEFORE2) ? BEFORE1 : BEFORE2;
   localparam int unsigned IN_DEPTH = MAXB + AFTER1 + AFTER2 + 1;
   localparam int unsigned M1_LEN   = BEFORE1 + AFTER1 + 1;
   localparam int unsigned M2_LEN   = BEFORE2 + AFTER2 + 1;
   localparam int unsigned LIST_MAX = (M1_LEN > M2_LEN) ? M1_LEN : M2_LEN;
   localparam int unsigned MID1     = M1_LEN / 2;
   localparam int unsigned MID2     = M2_LEN / 2;

   // odd-even transposition layers applied in each pipeline stage
   localparam int unsigned LAYERS_PER_STAGE = 2;
   localparam int unsigned SORT1_STAGES = (M1_LEN + LAYERS_PER_STAGE - 1) / LAYERS_PER_STAGE;
   localparam int unsigned SORT2_STAGES = (M2_LEN + LAYERS_PER_STAGE - 1) / LAYERS_PER_STAGE;

   typedef logic signed [15:0] sample_type;
   typedef sample_type list_type [LIST_MAX];
   typedef sample_type tap_type [M2_LEN];

   typedef struct packed {
      sample_type right;
      sample_type left;
   } pair_type;

   typedef struct {
      sample_type m1_left;
      sample_type m1_right;
      tap_type    x_left;
      tap_type    x_right;
   } m1_item_type;

   // Apply the layers of one pipeline stage to the first n entries.
   function automatic list_type sort_step(list_type a, int unsigned step, int unsigned n);
      list_type    r;
      list_type    t;
      int unsigned layer;
      r = a;
      for (int unsigned s = 0; s < LAYERS_PER_STAGE; s++) begin
         layer = step * LAYERS_PER_STAGE + s;
         t = r;
         for (int unsigned j = 0; j + 1 < LIST_MAX; j++) begin
            if (layer < n && j + 1 < n && (j % 2) == (layer % 2) && t[j] > t[j + 1]) begin
               r[j]     = t[j + 1];
               r[j + 1] = t[j];
            end
         end
      end
      return r;
   endfunction

   function automatic logic is_sorted(list_type a, int unsigned n);
      logic ok;
      ok = 1'b1;
      for (int unsigned j = 0; j + 1 < LIST_MAX; j++) begin
         if (j + 1 < n && a[j] > a[j + 1]) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

endpackage

FILE: design/sdmf_req_if.sv
`timescale 1ns / 1ps
interface sdmf_req_if;
   logic                 valid;
   logic                 ready;
   sdmf_pkg::sample_type left_in;
   sdmf_pkg::sample_type right_in;

   modport source (output valid, output left_in, output right_in, input ready);
   modport sink (input valid, input left_in, input right_in, output ready);
endinterface

FILE: design/sdmf_rsp_if.sv
`timescale 1ns / 1ps
interface sdmf_rsp_if;
   logic                 valid;
   logic                 ready;
   sdmf_pkg::sample_type left_out;
   sdmf_pkg::sample_type right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink (input valid, input left_out, input right_out, output ready);
endinterface

FILE: design/sdmf_median1.sv
`timescale 1ns / 1ps
module sdmf_median1 (
   input  logic                  clock,
   input  logic                  reset,
   sdmf_req_if.sink              req,
   output logic                  out_valid,
   input  logic                  out_ready,
   output sdmf_pkg::m1_item_type out_item
);

   localparam int unsigned S = sdmf_pkg::SORT1_STAGES;

   typedef struct {
      sdmf_pkg::list_type l;
      sdmf_pkg::list_type r;
      sdmf_pkg::tap_type  x_left;
      sdmf_pkg::tap_type  x_right;
   } stage_type;

   sdmf_pkg::pair_type win_ff [sdmf_pkg::IN_DEPTH];
   sdmf_pkg::pair_type win_in [sdmf_pkg::IN_DEPTH];
   stage_type          pipe_ff [S + 1];
   stage_type          pipe_in [S + 1];
   logic [S:0]         valid_ff;
   logic [S:0]         load;
   logic               accept;

   // a stage loads when empty or when its successor takes its item
   always_comb begin
      load[S] = !valid_ff[S] || out_ready;
      for (int k = S - 1; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k + 1];
      end
   end

   assign req.ready = load[0];
   assign accept    = req.valid && load[0];

   always_comb begin
      win_in[0] = {req.right_in, req.left_in};
      for (int i = 1; i < sdmf_pkg::IN_DEPTH; i++) begin
         win_in[i] = win_ff[i - 1];
      end
   end

   always_comb begin
      for (int i = 0; i < sdmf_pkg::LIST_MAX; i++) begin
         pipe_in[0].l[i] = '0;
         pipe_in[0].r[i] = '0;
      end
      for (int i = 0; i < sdmf_pkg::M1_LEN; i++) begin
         pipe_in[0].l[i] = win_in[i].left;
         pipe_in[0].r[i] = win_in[i].right;
      end
      // carry the samples that stage two pairs with the medians
      for (int i = 0; i < sdmf_pkg::M2_LEN; i++) begin
         pipe_in[0].x_left[i]  = win_in[sdmf_pkg::AFTER1 + i].left;
         pipe_in[0].x_right[i] = win_in[sdmf_pkg::AFTER1 + i].right;
      end
      for (int k = 1; k <= S; k++) begin
         pipe_in[k].l = sdmf_pkg::sort_step(pipe_ff[k - 1].l, k - 1, sdmf_pkg::M1_LEN);
         pipe_in[k].r = sdmf_pkg::sort_step(pipe_ff[k - 1].r, k - 1, sdmf_pkg::M1_LEN);
         pipe_in[k].x_left  = pipe_ff[k - 1].x_left;
         pipe_in[k].x_right = pipe_ff[k - 1].x_right;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < sdmf_pkg::IN_DEPTH; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         if (accept) begin
            for (int i = 0; i < sdmf_pkg::IN_DEPTH; i++) begin
               win_ff[i] <= win_in[i];
            end
         end
         if (load[0]) begin
            valid_ff[0] <= req.valid;
         end
         for (int k = 1; k <= S; k++) begin
            if (load[k]) begin
               valid_ff[k] <= valid_ff[k - 1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= S; k++) begin
         if (load[k]) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   assign out_valid        = valid_ff[S];
   assign out_item.m1_left  = pipe_ff[S].l[sdmf_pkg::MID1];
   assign out_item.m1_right = pipe_ff[S].r[sdmf_pkg::MID1];
   assign out_item.x_left   = pipe_ff[S].x_left;
   assign out_item.x_right  = pipe_ff[S].x_right;

   a_sorted: assert property (@(posedge clock) disable iff (reset)
      valid_ff[S] |-> (sdmf_pkg::is_sorted(pipe_ff[S].l, sdmf_pkg::M1_LEN) &&
                       sdmf_pkg::is_sorted(pipe_ff[S].r, sdmf_pkg::M1_LEN)))
      else $error("stage one list not sorted at the last stage");

   a_window: assert property (@(posedge clock) disable iff (reset)
      accept |=> win_ff[0] == $past({req.right_in, req.left_in}))
      else $error("input window did not take the accepted item");

   a_full: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> ((&valid_ff) && !out_ready))
      else $error("input stalled while the pipeline has room");

endmodule

FILE: design/sdmf_median2.sv
`timescale 1ns / 1ps
module sdmf_median2 (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  sdmf_pkg::m1_item_type in_item,
   sdmf_rsp_if.source            rsp
);

   localparam int unsigned S = sdmf_pkg::SORT2_STAGES;

   typedef struct {
      sdmf_pkg::list_type   l;
      sdmf_pkg::list_type   r;
      sdmf_pkg::sample_type c_left;
      sdmf_pkg::sample_type c_right;
   } stage_type;

   sdmf_pkg::pair_type   fmw_ff [sdmf_pkg::M2_LEN];
   sdmf_pkg::pair_type   fmw_in [sdmf_pkg::M2_LEN];
   stage_type            pipe_ff [S + 1];
   stage_type            pipe_in [S + 1];
   logic [S:0]           valid_ff;
   logic [S:0]           load;
   logic                 accept;
   logic                 out_load;
   logic                 out_valid_ff;
   sdmf_pkg::sample_type out_left_ff;
   sdmf_pkg::sample_type out_right_ff;
   sdmf_pkg::sample_type out_left_in;
   sdmf_pkg::sample_type out_right_in;

   // (x - m) / 2 truncated toward zero; the result always fits 16 bits
   function automatic sdmf_pkg::sample_type half_diff(sdmf_pkg::sample_type x,
                                                     sdmf_pkg::sample_type m);
      logic signed [16:0] d;
      logic signed [16:0] t;
      d = {x[15], x} - {m[15], m};
      t = d + {16'b0, d[16]};
      return t[16:1];
   endfunction

   assign out_load = !out_valid_ff || rsp.ready;

   always_comb begin
      load[S] = !valid_ff[S] || out_load;
      for (int k = S - 1; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k + 1];
      end
   end

   assign in_ready = load[0];
   assign accept   = in_valid && load[0];

   always_comb begin
      fmw_in[0] = {in_item.m1_right, in_item.m1_left};
      for (int i = 1; i < sdmf_pkg::M2_LEN; i++) begin
         fmw_in[i] = fmw_ff[i - 1];
      end
   end

   always_comb begin
      for (int i = 0; i < sdmf_pkg::LIST_MAX; i++) begin
         pipe_in[0].l[i] = '0;
         pipe_in[0].r[i] = '0;
      end
      for (int i = 0; i < sdmf_pkg::M2_LEN; i++) begin
         pipe_in[0].l[i] = half_diff(in_item.x_left[i], fmw_in[i].left);
         pipe_in[0].r[i] = half_diff(in_item.x_right[i], fmw_in[i].right);
      end
      pipe_in[0].c_left  = fmw_in[sdmf_pkg::AFTER2].left;
      pipe_in[0].c_right = fmw_in[sdmf_pkg::AFTER2].right;
      for (int k = 1; k <= S; k++) begin
         pipe_in[k].l = sdmf_pkg::sort_step(pipe_ff[k - 1].l, k - 1, sdmf_pkg::M2_LEN);
         pipe_in[k].r = sdmf_pkg::sort_step(pipe_ff[k - 1].r, k - 1, sdmf_pkg::M2_LEN);
         pipe_in[k].c_left  = pipe_ff[k - 1].c_left;
         pipe_in[k].c_right = pipe_ff[k - 1].c_right;
      end
   end

   // double the median and add the centre stage-one median, wrapping to 16 bits
   assign out_left_in  = {pipe_ff[S].l[sdmf_pkg::MID2][14:0], 1'b0} + pipe_ff[S].c_left;
   assign out_right_in = {pipe_ff[S].r[sdmf_pkg::MID2][14:0], 1'b0} + pipe_ff[S].c_right;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < sdmf_pkg::M2_LEN; i++) begin
            fmw_ff[i] <= '0;
         end
      end else begin
         if (accept) begin
            for (int i = 0; i < sdmf_pkg::M2_LEN; i++) begin
               fmw_ff[i] <= fmw_in[i];
            end
         end
         if (load[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k <= S; k++) begin
            if (load[k]) begin
               valid_ff[k] <= valid_ff[k - 1];
            end
         end
         if (out_load) begin
            out_valid_ff <= valid_ff[S];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= S; k++) begin
         if (load[k]) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
      if (out_load) begin
         out_left_ff  <= out_left_in;
         out_right_ff <= out_right_in;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.left_out  = out_left_ff;
   assign rsp.right_out = out_right_ff;

   a_sorted: assert property (@(posedge clock) disable iff (reset)
      valid_ff[S] |-> (sdmf_pkg::is_sorted(pipe_ff[S].l, sdmf_pkg::M2_LEN) &&
                       sdmf_pkg::is_sorted(pipe_ff[S].r, sdmf_pkg::M2_LEN)))
      else $error("stage two list not sorted at the last stage");

   a_median_window: assert property (@(posedge clock) disable iff (reset)
      accept |=> fmw_ff[0] == $past({in_item.m1_right, in_item.m1_left}))
      else $error("median window did not take the accepted item");

   a_full: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> ((&valid_ff) && out_valid_ff && !rsp.ready))
      else $error("stage two stalled while it has room");

endmodule

FILE: design/stereo_double_median_filter_top.sv
`timescale 1ns / 1ps
// Stereo double median filter.
// req carries one stereo pair (left_in, right_in) per item, rsp one filtered
// pair (left_out, right_out); both use valid/ready, an item moves on a rising
// clock edge with valid and ready high. Every accepted item gives exactly one
// result, in order. A result belongs to the input taken AFTER1 + AFTER2 items
// earlier; the first results come from the zero-filled windows.
// Throughput: one item per cycle while rsp.ready stays high. Each item passes
// the window capture, the two odd-even transposition sorting pipelines, two
// layers per stage, then the difference stage and the output register.
// Reset clears both sample windows to zero and empties the pipeline.
// When the receiver holds rsp.ready low the result stays in the output
// register; the pipeline keeps taking items until every stage is full, and
// only then drops req.ready. Nothing is lost or repeated.
module stereo_double_median_filter_top (
   input logic        clock,
   input logic        reset,
   sdmf_req_if.sink   req,
   sdmf_rsp_if.source rsp
);

   logic                  m1_valid;
   logic                  m1_ready;
   sdmf_pkg::m1_item_type m1_item;

   sdmf_median1 u_median1 (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .out_valid (m1_valid),
      .out_ready (m1_ready),
      .out_item  (m1_item)
   );

   sdmf_median2 u_median2 (
      .clock    (clock),
      .reset    (reset),
      .in_valid (m1_valid),
      .in_ready (m1_ready),
      .in_item  (m1_item),
      .rsp      (rsp)
   );

endmodule

FILE: tb/sv/stereo_double_median_filter_top_tb.sv
`timescale 1ns / 1ps
module stereo_double_median_filter_top_tb;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 30;

   class median_scoreboard;
      sdmf_pkg::sample_type in_left  [sdmf_pkg::IN_DEPTH];
      sdmf_pkg::sample_type in_right [sdmf_pkg::IN_DEPTH];
      sdmf_pkg::sample_type m1_left  [sdmf_pkg::M2_LEN];
      sdmf_pkg::sample_type m1_right [sdmf_pkg::M2_LEN];
      sdmf_pkg::pair_type   filtered_q[$];
      int                   mismatches;
      int                   inputs;
      int                   checked;

      function new();
         foreach (in_left[i]) begin
            in_left[i]  = '0;
            in_right[i] = '0;
         end
         foreach (m1_left[i]) begin
            m1_left[i]  = '0;
            m1_right[i] = '0;
         end
         mismatches = 0;
         inputs     = 0;
         checked    = 0;
      endfunction

      function int median_pick(int vals[sdmf_pkg::LIST_MAX], int n);
         int s[sdmf_pkg::LIST_MAX];
         int j;
         int v;
         for (int i = 0; i < n; i++) begin
            v = vals[i];
            j = i;
            while (j > 0 && s[j - 1] > v) begin
               s[j] = s[j - 1];
               j--;
            end
            s[j] = v;
         end
         return s[n / 2];
      endfunction

      // Shift the pair into both windows and queue the filtered pair it yields.
      function void note_input(sdmf_pkg::sample_type l, sdmf_pkg::sample_type r);
         int                 lv[sdmf_pkg::LIST_MAX];
         int                 rv[sdmf_pkg::LIST_MAX];
         int                 l1, r1, lh, rh;
         sdmf_pkg::pair_type res;
         for (int i = sdmf_pkg::IN_DEPTH - 1; i > 0; i--) begin
            in_left[i]  = in_left[i - 1];
            in_right[i] = in_right[i - 1];
         end
         in_left[0]  = l;
         in_right[0] = r;
         foreach (lv[i]) begin
            lv[i] = 0;
            rv[i] = 0;
         end
         for (int i = 0; i < sdmf_pkg::M1_LEN; i++) begin
            lv[i] = int'(in_left[i]);
            rv[i] = int'(in_right[i]);
         end
         l1 = median_pick(lv, sdmf_pkg::M1_LEN);
         r1 = median_pick(rv, sdmf_pkg::M1_LEN);
         for (int i = sdmf_pkg::M2_LEN - 1; i > 0; i--) begin
            m1_left[i]  = m1_left[i - 1];
            m1_right[i] = m1_right[i - 1];
         end
         m1_left[0]  = sdmf_pkg::sample_type'(l1);
         m1_right[0] = sdmf_pkg::sample_type'(r1);
         // halves truncate toward zero, as SV integer division does
         for (int i = 0; i < sdmf_pkg::M2_LEN; i++) begin
            lv[i] = (int'(in_left[sdmf_pkg::AFTER1 + i]) - int'(m1_left[i])) / 2;
            rv[i] = (int'(in_right[sdmf_pkg::AFTER1 + i]) - int'(m1_right[i])) / 2;
         end
         lh = median_pick(lv, sdmf_pkg::M2_LEN);
         rh = median_pick(rv, sdmf_pkg::M2_LEN);
         res.left  = sdmf_pkg::sample_type'(lh * 2 + int'(m1_left[sdmf_pkg::AFTER2]));
         res.right = sdmf_pkg::sample_type'(rh * 2 + int'(m1_right[sdmf_pkg::AFTER2]));
         filtered_q.push_back(res);
         inputs++;
      endfunction

      function void check_output(sdmf_pkg::sample_type l, sdmf_pkg::sample_type r);
         sdmf_pkg::pair_type want;
         if (filtered_q.size() == 0) begin
            $error("unexpected result: left_out %0d right_out %0d", l, r);
            mismatches++;
            return;
         end
         want = filtered_q.pop_front();
         checked++;
         if (l !== want.left) begin
            $error("left_out mismatch: expected %0d, got %0d", want.left, l);
            mismatches++;
         end
         if (r !== want.right) begin
            $error("right_out mismatch: expected %0d, got %0d", want.right, r);
            mismatches++;
         end
      endfunction

      function int pending();
         return filtered_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   sdmf_req_if req_ch ();
   sdmf_rsp_if rsp_ch ();

   stereo_double_median_filter_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   median_scoreboard sb = new();

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_request   = 0;
   int hold_left      = 0;
   int idle_cycles    = 0;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // receiver: random stalls, or a long hold-off when one is requested
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_output(rsp_ch.left_out, rsp_ch.right_out);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("stereo_double_median_filter_top verification failed");
            $finish;
         end
      end
   end

   // Offer one pair, entered at a falling edge; return at the falling edge after it is taken.
   task automatic send_pair(sdmf_pkg::sample_type l, sdmf_pkg::sample_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid    = 1'b1;
      req_ch.left_in  = l;
      req_ch.right_in = r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_input(l, r);
      @(negedge clock);
   endtask

   function automatic sdmf_pkg::sample_type pick_extreme();
      case ($urandom_range(4))
         0: return sdmf_pkg::sample_type'(16'sh7FFF);
         1: return sdmf_pkg::sample_type'(16'sh8000);
         2: return sdmf_pkg::sample_type'(16'sh0000);
         3: return sdmf_pkg::sample_type'(16'shFFFF);
         default: return sdmf_pkg::sample_type'(16'sh0001);
      endcase
   endfunction

   // Bursts of shaped audio: slow walks and flat levels with impulse spikes,
   // plus plain noise and runs of extremes.
   task automatic run_random(int count);
      int                   sent;
      int                   burst;
      int                   style;
      sdmf_pkg::sample_type lv, rv, l, r;
      sent = 0;
      lv   = sdmf_pkg::sample_type'($urandom);
      rv   = sdmf_pkg::sample_type'($urandom);
      while (sent < count) begin
         burst = $urandom_range(8, 24);
         style = $urandom_range(99);
         for (int k = 0; k < burst && sent < count; k++) begin
            if (style < 40) begin
               lv = lv + sdmf_pkg::sample_type'($urandom_range(512) - 256);
               rv = rv + sdmf_pkg::sample_type'($urandom_range(512) - 256);
               l  = ($urandom_range(9) == 0) ? sdmf_pkg::sample_type'($urandom) : lv;
               r  = ($urandom_range(9) == 0) ? sdmf_pkg::sample_type'($urandom) : rv;
            end else if (style < 65) begin
               l = sdmf_pkg::sample_type'($urandom);
               r = sdmf_pkg::sample_type'($urandom);
            end else if (style < 80) begin
               l = pick_extreme();
               r = pick_extreme();
            end else begin
               l = ($urandom_range(7) == 0) ? pick_extreme() : lv;
               r = ($urandom_range(7) == 0) ? pick_extreme() : rv;
            end
            send_pair(l, r);
            sent++;
         end
      end
   endtask

   task automatic run_directed();
      sdmf_pkg::sample_type maxv, minv;
      maxv = sdmf_pkg::sample_type'(16'sh7FFF);
      minv = sdmf_pkg::sample_type'(16'sh8000);
      // zero-filled start of stream, then full-scale runs
      repeat (2) send_pair('0, '0);
      repeat (5) send_pair(maxv, minv);
      repeat (5) send_pair(minv, maxv);
      // alternate full scale to push the final sum past the range
      for (int k = 0; k < 6; k++) begin
         send_pair((k % 2) ? maxv : minv, (k % 2) ? minv : maxv);
      end
      send_pair(sdmf_pkg::sample_type'(-1), sdmf_pkg::sample_type'(1));
      send_pair(sdmf_pkg::sample_type'(1), sdmf_pkg::sample_type'(-1));
      // single impulses on a flat negative floor
      send_pair(minv, minv);
      send_pair(maxv, maxv);
      send_pair(minv, minv);
      send_pair(sdmf_pkg::sample_type'(16'sh5555), sdmf_pkg::sample_type'(16'shAAAA));
      send_pair(sdmf_pkg::sample_type'(16'shAAAA), sdmf_pkg::sample_type'(16'sh5555));
   endtask

   initial begin
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.left_in  = '0;
      req_ch.right_in = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed();

      run_random(130);

      send_idle_pct = 60;
      run_random(130);

      send_idle_pct  = 0;
      recv_stall_pct = 60;
      run_random(130);

      // long hold-off at the output while input keeps coming: fill and stall
      recv_stall_pct = 0;
      hold_request   = 80;
      run_random(60);

      // let everything drain before the mixed phase
      req_ch.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);

      send_idle_pct  = 28;
      recv_stall_pct = 28;
      run_random(130);

      req_ch.valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (sb.pending() != 0) begin
         $error("%0d filtered pairs never arrived", sb.pending());
         sb.mismatches++;
      end
      $display("run: %0d stereo pairs sent, %0d filtered pairs checked", sb.inputs, sb.checked);
      $display("run: extremes, impulses, noise, idle/stall mixes and full backpressure");
      if (sb.mismatches == 0) begin
         $display("stereo_double_median_filter_top verification clean");
      end else begin
         $display("stereo_double_median_filter_top verification failed");
      end
      $finish;
   end

endmodule
